// File: rtl/spsl_pkg.sv
package spsl_pkg;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAG_REFERENCE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WET_MIX       = 2'd2;

  localparam int WINDOW_W = 15;
  localparam int REF_W    = 16;
  localparam int MIX_W    = 16;
  localparam int REF_FRAC = 8;
  localparam int MIX_FRAC = 15;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 15'd1;
  localparam logic [REF_W-1:0]    REF_RESET    = 16'd256;
  localparam logic [MIX_W-1:0]    MIX_RESET    = 16'd0;

  localparam int CHANNELS    = 2;
  localparam int QUEUE_DEPTH = 2;

  // how the back end forms the gain of one channel
  localparam int MODE_W = 2;
  typedef logic [MODE_W-1:0] gain_mode_t;
  localparam gain_mode_t GAIN_SAMPLE = 2'd0;  // sum is zero: gain follows the sample
  localparam gain_mode_t GAIN_UNITY  = 2'd1;  // reference at or above sum
  localparam gain_mode_t GAIN_DIVIDE = 2'd2;  // gain is reference over sum

  typedef struct packed {
    logic [WINDOW_W-1:0]     window_length;
    logic [REF_W-1:0]        sag_reference;
    logic signed [MIX_W-1:0] wet_mix;
  } cfg_t;

endpackage

// File: rtl/spsl_ram.sv
module spsl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/spsl_queue.sv
module spsl_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

endmodule

// File: rtl/spsl_front.sv
module spsl_front #(
  parameter int RING_DEPTH  = 16384,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  spsl_pkg::cfg_t                         cfg,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [SAMPLE_BITS-1:0]          in_left,
  input  logic signed [SAMPLE_BITS-1:0]          in_right,
  input  logic                                   in_last,
  output logic                                   push,
  output logic [2*SAMPLE_BITS + 2*($clog2(RING_DEPTH+1) + SAMPLE_BITS - 1)
                + 2*spsl_pkg::MODE_W:0]          push_data,
  input  logic                                   full
);

  localparam int F      = SAMPLE_BITS - 1;
  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int WIN_W  = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = WIN_W + F;
  localparam int SAW    = SUM_W + 2;
  localparam int ADR_W  = WIN_W + 1;
  localparam int NUM_W  = spsl_pkg::REF_W + F - spsl_pkg::REF_FRAC;
  localparam int CMP_W  = (NUM_W > SUM_W) ? NUM_W : SUM_W;

  localparam logic [1:0] FS_IDLE  = 2'd0;
  localparam logic [1:0] FS_SUM   = 2'd1;
  localparam logic [1:0] FS_CLASS = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [PTR_W-1:0]       ptr_r, ptr_nxt;
  logic [WIN_W-1:0]       fill_r, fill_nxt;
  logic [SUM_W-1:0]       sum_left_r, sum_left_nxt;
  logic [SUM_W-1:0]       sum_right_r, sum_right_nxt;
  logic signed [SAMPLE_BITS-1:0] x_left_r, x_right_r;
  logic                   last_r;

  logic [WIN_W-1:0]       win_eff;
  logic [ADR_W-1:0]       rd_sum;
  logic [ADR_W-1:0]       rd_addr;
  logic [SUM_W-1:0]       limit;
  logic [NUM_W-1:0]       num;
  logic                   accept;
  logic                   old_valid;
  logic                   ring_we;
  logic [SAMPLE_BITS-1:0] mag_left, mag_right;
  logic [SAMPLE_BITS-1:0] rdata_left, rdata_right;
  logic [SAMPLE_BITS-1:0] old_left, old_right;
  spsl_pkg::gain_mode_t   mode_left, mode_right;

  function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] x);
    return x[SAMPLE_BITS-1] ? (~x + SAMPLE_BITS'(1)) : x;
  endfunction

  function automatic logic [SUM_W-1:0] sum_update(input logic [SUM_W-1:0]       sum,
                                                  input logic [SAMPLE_BITS-1:0] mag,
                                                  input logic [SAMPLE_BITS-1:0] old,
                                                  input logic [SUM_W-1:0]       lim);
    logic signed [SAW-1:0] acc;
    acc = $signed(SAW'(sum)) + $signed(SAW'(mag)) - $signed(SAW'(old));
    if (acc < 0) begin
      return '0;
    end else if (acc > $signed(SAW'(lim))) begin
      return lim;
    end
    return acc[SUM_W-1:0];
  endfunction

  function automatic spsl_pkg::gain_mode_t classify(input logic [SUM_W-1:0] sum,
                                                    input logic [NUM_W-1:0] n);
    if (sum == '0) begin
      return spsl_pkg::GAIN_SAMPLE;
    end else if (CMP_W'(n) >= CMP_W'(sum)) begin
      return spsl_pkg::GAIN_UNITY;
    end
    return spsl_pkg::GAIN_DIVIDE;
  endfunction

  // zero acts as one, anything above the ring depth as the depth
  always_comb begin
    if (cfg.window_length == '0) begin
      win_eff = WIN_W'(1);
    end else if (32'(cfg.window_length) > RING_DEPTH) begin
      win_eff = WIN_W'(RING_DEPTH);
    end else begin
      win_eff = WIN_W'(cfg.window_length);
    end
  end

  assign rd_sum  = ADR_W'(ptr_r) + ADR_W'(win_eff);
  assign rd_addr = (rd_sum >= ADR_W'(RING_DEPTH)) ? rd_sum - ADR_W'(RING_DEPTH) : rd_sum;
  assign limit   = {win_eff, {F{1'b0}}};
  assign num     = {cfg.sag_reference, {(F - spsl_pkg::REF_FRAC){1'b0}}};

  assign in_ready = (state_r == FS_IDLE);
  assign accept   = in_ready && in_valid;
  assign ring_we  = (state_r == FS_SUM);

  // entries never written since reset read as zero
  assign old_valid = (fill_r >= win_eff);
  assign old_left  = old_valid ? rdata_left  : '0;
  assign old_right = old_valid ? rdata_right : '0;
  assign mag_left  = magnitude(x_left_r);
  assign mag_right = magnitude(x_right_r);

  assign mode_left  = classify(sum_left_r, num);
  assign mode_right = classify(sum_right_r, num);

  assign push      = (state_r == FS_CLASS) && !full;
  assign push_data = {last_r, mode_right, mode_left, sum_right_r, sum_left_r,
                      x_right_r, x_left_r};

  spsl_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring_left (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ptr_r),
    .wdata (mag_left),
    .re    (accept),
    .raddr (rd_addr[PTR_W-1:0]),
    .rdata (rdata_left)
  );

  spsl_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring_right (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ptr_r),
    .wdata (mag_right),
    .re    (accept),
    .raddr (rd_addr[PTR_W-1:0]),
    .rdata (rdata_right)
  );

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    fill_nxt      = fill_r;
    sum_left_nxt  = sum_left_r;
    sum_right_nxt = sum_right_r;
    case (state_r)
      FS_IDLE: begin
        if (in_valid) begin
          state_nxt = FS_SUM;
        end
      end
      FS_SUM: begin
        sum_left_nxt  = sum_update(sum_left_r, mag_left, old_left, limit);
        sum_right_nxt = sum_update(sum_right_r, mag_right, old_right, limit);
        ptr_nxt       = (ptr_r == '0) ? PTR_W'(RING_DEPTH - 1) : ptr_r - PTR_W'(1);
        fill_nxt      = (fill_r == WIN_W'(RING_DEPTH)) ? fill_r : fill_r + WIN_W'(1);
        state_nxt     = FS_CLASS;
      end
      FS_CLASS: begin
        // hold until the queue has room
        if (!full) begin
          state_nxt = FS_IDLE;
        end
      end
      default: begin
        state_nxt = FS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FS_IDLE;
      ptr_r       <= PTR_W'(RING_DEPTH - 1);
      fill_r      <= '0;
      sum_left_r  <= '0;
      sum_right_r <= '0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      fill_r      <= fill_nxt;
      sum_left_r  <= sum_left_nxt;
      sum_right_r <= sum_right_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_left_r  <= in_left;
      x_right_r <= in_right;
      last_r    <= in_last;
    end
  end

endmodule

// File: rtl/spsl_back.sv
module spsl_back #(
  parameter int RING_DEPTH  = 16384,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spsl_pkg::cfg_t                cfg,
  input  logic                          pop_valid,
  output logic                          pop,
  input  logic [2*SAMPLE_BITS + 2*($clog2(RING_DEPTH+1) + SAMPLE_BITS - 1)
                + 2*spsl_pkg::MODE_W:0] pop_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right,
  output logic                          out_last
);

  localparam int S     = SAMPLE_BITS;
  localparam int F     = SAMPLE_BITS - 1;
  localparam int CH    = spsl_pkg::CHANNELS;
  localparam int WIN_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = WIN_W + F;
  localparam int NUM_W = spsl_pkg::REF_W + F - spsl_pkg::REF_FRAC;
  localparam int MW    = spsl_pkg::MIX_W;
  localparam int G_W   = F + 1;
  localparam int P1_W  = S + G_W + 1;
  localparam int D_W   = S + 2;
  localparam int P2_W  = D_W + MW;
  localparam int P3_W  = S + MW + 1;
  localparam int O_W   = S + 4;
  localparam int CNT_W = $clog2(F);
  localparam int SUM_BASE  = CH * S;
  localparam int MODE_BASE = SUM_BASE + CH * SUM_W;
  localparam int LAST_POS  = MODE_BASE + CH * spsl_pkg::MODE_W;

  localparam logic [2:0] BS_IDLE = 3'd0;
  localparam logic [2:0] BS_DIV  = 3'd1;
  localparam logic [2:0] BS_MUL1 = 3'd2;
  localparam logic [2:0] BS_MUL2 = 3'd3;
  localparam logic [2:0] BS_OUT  = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   load;
  logic                   any_div;

  logic signed [S-1:0]    x_r     [CH];
  logic [SUM_W-1:0]       s_r     [CH];
  spsl_pkg::gain_mode_t   mode_r  [CH];
  logic [SUM_W-1:0]       rem_r   [CH];
  logic [F-1:0]           quo_r   [CH];
  logic signed [P1_W-1:0] prod1_r [CH];
  logic signed [P2_W-1:0] prod2_r [CH];
  logic signed [P3_W-1:0] prod3_r [CH];
  logic                   last_r;
  logic signed [S-1:0]    out_r   [CH];
  logic                   out_last_r;

  logic signed [S-1:0]    in_x    [CH];
  logic [SUM_W-1:0]       in_s    [CH];
  spsl_pkg::gain_mode_t   in_mode [CH];
  logic [SUM_W:0]         rem2    [CH];
  logic                   ge      [CH];
  logic [G_W-1:0]         gain    [CH];
  logic signed [P1_W-1:0] p1sh    [CH];
  logic signed [S:0]      wet     [CH];
  logic signed [D_W-1:0]  diff    [CH];
  logic signed [P2_W-1:0] p2sh    [CH];
  logic signed [P3_W-1:0] p3sh    [CH];
  logic signed [O_W-1:0]  dry     [CH];
  logic signed [O_W-1:0]  mixed   [CH];
  logic signed [S-1:0]    sat     [CH];

  logic [NUM_W-1:0]       num;
  logic signed [MW:0]     dry_scale;
  logic signed [O_W-1:0]  hi_lim, lo_lim;

  assign num       = {cfg.sag_reference, {(F - spsl_pkg::REF_FRAC){1'b0}}};
  // dry scale 1 + wet_mix, used only for a negative mix
  assign dry_scale = $signed({cfg.wet_mix[MW-1], cfg.wet_mix}
                             + (MW+1)'(1 << spsl_pkg::MIX_FRAC));
  assign hi_lim    = $signed({{(O_W-F){1'b0}}, {F{1'b1}}});
  assign lo_lim    = $signed({{(O_W-F){1'b1}}, {F{1'b0}}});

  assign pop  = (state_r == BS_IDLE) && pop_valid;
  assign load = (state_r == BS_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    any_div = 1'b0;
    for (int i = 0; i < CH; i++) begin
      in_x[i]    = $signed(pop_data[i*S +: S]);
      in_s[i]    = pop_data[SUM_BASE + i*SUM_W +: SUM_W];
      in_mode[i] = pop_data[MODE_BASE + i*spsl_pkg::MODE_W +: spsl_pkg::MODE_W];
      if (in_mode[i] == spsl_pkg::GAIN_DIVIDE) begin
        any_div = 1'b1;
      end

      // one quotient bit per cycle, restoring
      rem2[i] = {rem_r[i], 1'b0};
      ge[i]   = (rem2[i] >= {1'b0, s_r[i]});

      case (mode_r[i])
        spsl_pkg::GAIN_SAMPLE: gain[i] = x_r[i][S-1] ? '0 : G_W'(x_r[i]);
        spsl_pkg::GAIN_UNITY:  gain[i] = {1'b1, {F{1'b0}}};
        spsl_pkg::GAIN_DIVIDE: gain[i] = {1'b0, quo_r[i]};
        default:               gain[i] = '0;
      endcase

      p1sh[i]  = prod1_r[i] >>> F;
      wet[i]   = $signed(p1sh[i][S:0]);
      diff[i]  = D_W'(x_r[i]) - D_W'(wet[i]);

      p2sh[i]  = prod2_r[i] >>> spsl_pkg::MIX_FRAC;
      p3sh[i]  = prod3_r[i] >>> spsl_pkg::MIX_FRAC;
      dry[i]   = cfg.wet_mix[MW-1] ? O_W'(p3sh[i]) : O_W'(x_r[i]);
      mixed[i] = dry[i] - O_W'(p2sh[i]);
      if (mixed[i] > hi_lim) begin
        sat[i] = $signed({1'b0, {F{1'b1}}});
      end else if (mixed[i] < lo_lim) begin
        sat[i] = $signed({1'b1, {F{1'b0}}});
      end else begin
        sat[i] = mixed[i][S-1:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      BS_IDLE: begin
        if (pop_valid) begin
          state_nxt = any_div ? BS_DIV : BS_MUL1;
          cnt_nxt   = CNT_W'(F - 1);
        end
      end
      BS_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = BS_MUL1;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      BS_MUL1: state_nxt = BS_MUL2;
      BS_MUL2: state_nxt = BS_OUT;
      BS_OUT: begin
        if (load) begin
          state_nxt = BS_IDLE;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      last_r <= pop_data[LAST_POS];
    end
    if (load) begin
      out_last_r <= last_r;
    end
    for (int i = 0; i < CH; i++) begin
      case (state_r)
        BS_IDLE: begin
          if (pop) begin
            x_r[i]    <= in_x[i];
            s_r[i]    <= in_s[i];
            mode_r[i] <= in_mode[i];
            rem_r[i]  <= SUM_W'(num);
            quo_r[i]  <= '0;
          end
        end
        BS_DIV: begin
          rem_r[i] <= ge[i] ? SUM_W'(rem2[i] - {1'b0, s_r[i]}) : rem2[i][SUM_W-1:0];
          quo_r[i] <= {quo_r[i][F-2:0], ge[i]};
        end
        BS_MUL1: begin
          prod1_r[i] <= x_r[i] * $signed({1'b0, gain[i]});
          prod3_r[i] <= x_r[i] * dry_scale;
        end
        BS_MUL2: begin
          prod2_r[i] <= diff[i] * cfg.wet_mix;
        end
        BS_OUT: begin
          if (load) begin
            out_r[i] <= sat[i];
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_left  = out_r[0];
  assign out_right = out_r[1];
  assign out_last  = out_last_r;

endmodule

// File: rtl/stereo_power_sag_limiter.sv
// Stereo power-sag limiter.
// in_*  : stream of stereo frames, in_tdata = {right, left} samples of SAMPLE_BITS each,
//         in_tlast marks the last frame of a host block and comes back as out_tlast.
// out_* : one processed frame for every frame taken, same packing, saturated.
// cfg_* : register writes (window length, sag reference, wet mix), always ready;
//         write only while no frame is in flight.
// The front end takes a new frame only after the last one has gone into the queue: it
// reads the old magnitude from each channel's ring, writes the new one and updates the
// running sums. A two-entry queue feeds the back end, which forms the gain and the
// wet/dry mix, going through the bit-serial gain divider first when a channel needs
// it, i.e. when the sum exceeds the reference; it pops a new frame only after the last
// one is in the output register.
// Reset empties the pipeline and clears the sums; rings need no clearing pass, since
// a fill count makes unwritten entries read as zero.
// A stalled receiver holds the output register; the back end finishes one more frame,
// the queue fills, and then in_tready drops until out_tready returns.
module stereo_power_sag_limiter #(
  parameter int RING_DEPTH  = 16384,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // sample_left, sample_right, zero pad to whole bytes
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,
  input  logic                                  in_tlast,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // out_left, out_right, zero pad to whole bytes
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    out_tdata,
  output logic                                  out_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [spsl_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [spsl_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int DATA_W = ((2*SAMPLE_BITS + 7) / 8) * 8;
  localparam int SUM_W  = $clog2(RING_DEPTH + 1) + SAMPLE_BITS - 1;
  localparam int Q_W    = 2*SAMPLE_BITS + 2*SUM_W + 2*spsl_pkg::MODE_W + 1;

  spsl_pkg::cfg_t cfg_r, cfg_nxt;

  logic                          q_push, q_pop, q_full, q_empty;
  logic [Q_W-1:0]                q_push_data, q_pop_data;
  logic signed [SAMPLE_BITS-1:0] out_left, out_right;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        spsl_pkg::CFG_WINDOW_LENGTH: cfg_nxt.window_length = cfg_data[spsl_pkg::WINDOW_W-1:0];
        spsl_pkg::CFG_SAG_REFERENCE: cfg_nxt.sag_reference = cfg_data;
        spsl_pkg::CFG_WET_MIX:       cfg_nxt.wet_mix       = $signed(cfg_data);
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_length <= spsl_pkg::WINDOW_RESET;
      cfg_r.sag_reference <= spsl_pkg::REF_RESET;
      cfg_r.wet_mix       <= $signed(spsl_pkg::MIX_RESET);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  spsl_front #(
    .RING_DEPTH  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_left   ($signed(in_tdata[SAMPLE_BITS-1:0])),
    .in_right  ($signed(in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
    .in_last   (in_tlast),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full)
  );

  spsl_queue #(
    .WIDTH (Q_W),
    .DEPTH (spsl_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  spsl_back #(
    .RING_DEPTH  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (!q_empty),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_left  (out_left),
    .out_right (out_right),
    .out_last  (out_tlast)
  );

  assign out_tdata = DATA_W'({out_right, out_left});

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("frame pushed into a full queue");

  a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("frame popped from an empty queue");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("block not idle after reset");

endmodule
